// ===== src/knn_pkg.sv =====
// Shared types and constants for the k-nearest-neighbor search block.
package knn_pkg;

    localparam int MaxEntries  = 256;
    localparam int NumFeatures = 5;
    localparam int MaxK        = 16;
    localparam int FeatureBits = 16;

    localparam int IdxW   = $clog2(MaxEntries);
    localparam int CntW   = $clog2(MaxEntries + 1);
    localparam int KW     = $clog2(MaxK + 1);
    localparam int SlotW  = $clog2(MaxK);
    localparam int VecW   = NumFeatures * FeatureBits;
    localparam int DistW  = 35;
    localparam int DiffW  = FeatureBits + 1;
    localparam int SqW    = 2 * DiffW;
    localparam int FeatSelW = (NumFeatures > 1) ? $clog2(NumFeatures) : 1;

    localparam logic [DistW-1:0] DistMax = '1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QVEC   = 2'd2,
        OP_QIDX   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOADQ,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic load_vec;     // take query from input word
        logic load_mem;     // take query from memory read data
        logic start_scan;
        logic scan;         // issue one entry read this cycle
        logic emit_start;
        logic emit_next;
        logic empty_out;
    } knn_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic            scan_done;   // all reads issued
        logic            pipe_empty;  // no distance in flight
        logic            held_zero;
        logic            emit_last;   // slot being shown is final
        logic            idx_bad;
    } knn_sts_t;

endpackage

// ===== src/k_nearest_neighbor_search.sv =====
// Top level of the k-nearest-neighbor search block.
// A query by vector reads every stored entry, one stored vector per cycle, through the single
// read port of the entry memory (a query by index first loads the named entry as the query),
// then emits its words, one word per cycle while m_tready is high. Input is taken only while
// idle, so a new query waits for the previous one to finish; clear/append one per cycle.
// Reset (aresetn low, synchronous): corpus emptied, output invalid; stored vectors kept.
module k_nearest_neighbor_search (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    // feature_0..4[79:0], entry_index[87:80], neighbor_count[92:88], pad
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // neighbor_index[7:0], distance_squared[42:8], pad
    output logic [47:0]  m_tdata,
    // found[0]
    output logic         m_tuser,
    output logic         m_tlast
);
    knn_pkg::knn_cmd_t cmd;
    knn_pkg::knn_sts_t sts;
    logic [7:0]  oidx;
    logic [34:0] odist;

    knn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (knn_pkg::opcode_t'(s_tuser)),
        .out_busy (m_tvalid && !m_tready),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    knn_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_vec    (s_tdata[79:0]),
        .in_index  (s_tdata[87:80]),
        .in_k      (s_tdata[92:88]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (oidx),
        .out_dist  (odist),
        .out_found (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {5'b0, odist, oidx};

endmodule

// ===== src/knn_ctrl.sv =====
// Controller state machine for the k-nearest-neighbor search block.
module knn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  knn_pkg::opcode_t  in_op,
    input  logic              out_busy,   // output register full and not taken
    output logic              in_ready,
    output knn_pkg::knn_cmd_t cmd,
    input  knn_pkg::knn_sts_t sts
);

    knn_pkg::state_t state_reg, state_next;
    logic            acc;

    assign acc = in_valid && in_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            knn_pkg::ST_IDLE: begin
                if (acc && in_op == knn_pkg::OP_QVEC) begin
                    state_next = knn_pkg::ST_SCAN;
                end else if (acc && in_op == knn_pkg::OP_QIDX) begin
                    state_next = knn_pkg::ST_LOADQ;
                end
            end
            knn_pkg::ST_LOADQ: begin
                state_next = sts.idx_bad ? knn_pkg::ST_EMIT : knn_pkg::ST_SCAN;
            end
            knn_pkg::ST_SCAN: begin
                if (sts.scan_done) state_next = knn_pkg::ST_DRAIN;
            end
            knn_pkg::ST_DRAIN: begin
                if (sts.pipe_empty) state_next = knn_pkg::ST_EMIT;
            end
            knn_pkg::ST_EMIT: begin
                if (!out_busy && (sts.emit_last || sts.held_zero || sts.idx_bad))
                    state_next = knn_pkg::ST_IDLE;
            end
            default: state_next = knn_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            knn_pkg::ST_IDLE: begin
                in_ready       = 1'b1;
                cmd.clear      = acc && in_op == knn_pkg::OP_CLEAR;
                cmd.append     = acc && in_op == knn_pkg::OP_APPEND;
                cmd.load_vec   = acc && (in_op == knn_pkg::OP_QVEC || in_op == knn_pkg::OP_QIDX);
                cmd.start_scan = acc && in_op == knn_pkg::OP_QVEC;
            end
            knn_pkg::ST_LOADQ: begin
                cmd.load_mem   = 1'b1;
                cmd.start_scan = !sts.idx_bad;
            end
            knn_pkg::ST_SCAN: begin
                cmd.scan = !sts.scan_done;
            end
            knn_pkg::ST_DRAIN: begin
                cmd.emit_start = sts.pipe_empty;
            end
            knn_pkg::ST_EMIT: begin
                if (!out_busy) begin
                    cmd.empty_out = sts.held_zero || sts.idx_bad;
                    cmd.emit_next = !(sts.held_zero || sts.idx_bad);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= knn_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

endmodule

// ===== src/knn_dp.sv =====
// Datapath: entry memory, distance pipeline, sorted best list, output register.
module knn_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  knn_pkg::knn_cmd_t           cmd,
    output knn_pkg::knn_sts_t           sts,
    input  logic [knn_pkg::VecW-1:0]    in_vec,
    input  logic [knn_pkg::IdxW-1:0]    in_index,
    input  logic [4:0]                  in_k,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [knn_pkg::IdxW-1:0]    out_index,
    output logic [knn_pkg::DistW-1:0]   out_dist,
    output logic                        out_found,
    output logic                        out_last
);
    localparam int IdxW  = knn_pkg::IdxW;
    localparam int CntW  = knn_pkg::CntW;
    localparam int FB    = knn_pkg::FeatureBits;
    localparam int NF    = knn_pkg::NumFeatures;
    localparam int DistW = knn_pkg::DistW;
    localparam int KW    = knn_pkg::KW;
    localparam int MK    = knn_pkg::MaxK;

    // entry memory
    logic [knn_pkg::VecW-1:0] mem [knn_pkg::MaxEntries];
    logic [knn_pkg::VecW-1:0] rd_data_reg;
    logic [IdxW-1:0]          rd_addr;
    logic [CntW-1:0]          count_reg;
    logic [CntW-1:0]          scan_reg;

    always_ff @(posedge aclk) begin
        if (cmd.append && count_reg < CntW'(knn_pkg::MaxEntries))
            mem[count_reg[IdxW-1:0]] <= in_vec;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_addr = cmd.load_vec ? in_index : scan_reg[IdxW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.append && count_reg < CntW'(knn_pkg::MaxEntries)) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // query registers
    logic [knn_pkg::VecW-1:0] q_reg;
    logic [IdxW-1:0]          qidx_reg;
    logic                     excl_reg;
    logic [KW-1:0]            k_reg;
    logic                     bad_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_vec) begin
            q_reg    <= in_vec;
            qidx_reg <= in_index;
            excl_reg <= 1'b0;
            k_reg    <= (in_k > 5'(MK)) ? KW'(MK) : KW'(in_k);
            // index query (no scan start yet) naming an entry not stored
            bad_reg  <= !cmd.start_scan && ({1'b0, in_index} >= count_reg);
        end else if (cmd.load_mem) begin
            q_reg    <= rd_data_reg;
            excl_reg <= 1'b1;
        end
    end

    // scan counter: one entry read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.start_scan)  scan_reg <= '0;
        else if (cmd.scan)   scan_reg <= scan_reg + 1'b1;
    end

    // pipeline valid/index tags: read -> diff/square -> sum
    logic           v1_reg, v2_reg, v3_reg;
    logic [IdxW-1:0] i1_reg, i2_reg, i3_reg;
    logic [2*(FB+1)-1:0] sq_reg [NF];
    logic [DistW-1:0]    sum_reg;
    logic [DistW-1:0]    sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.scan && !(excl_reg && scan_reg[IdxW-1:0] == qidx_reg);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // per-feature squares
    always_ff @(posedge aclk) begin
        i1_reg <= scan_reg[IdxW-1:0];
        i2_reg <= i1_reg;
        i3_reg <= i2_reg;
        for (int f = 0; f < NF; f++) begin
            logic signed [FB:0] d;
            logic [FB:0]        a;
            d = $signed({q_reg[f*FB+FB-1], q_reg[f*FB +: FB]})
              - $signed({rd_data_reg[f*FB+FB-1], rd_data_reg[f*FB +: FB]});
            a = d[FB] ? (~d + 1'b1) : d;
            sq_reg[f] <= a * a;
        end
    end

    // saturating sum of squares
    always_comb begin : sum_blk
        logic [DistW+3:0] s;
        s = '0;
        for (int f = 0; f < NF; f++) s = s + (DistW+4)'(sq_reg[f]);
        sum_next = (s > (DistW+4)'(knn_pkg::DistMax)) ? knn_pkg::DistMax : s[DistW-1:0];
    end

    always_ff @(posedge aclk) sum_reg <= sum_next;

    // sorted best list, insertion by shift
    logic [DistW-1:0] bd_reg [MK];
    logic [IdxW-1:0]  bi_reg [MK];
    logic [KW-1:0]    held_reg;
    logic [MK-1:0]    gt;       // slot j holds a larger distance than the new one
    logic [MK-1:0]    gt_prev;  // same flag for the slot below

    always_comb begin
        for (int j = 0; j < MK; j++)
            gt[j] = (KW'(j) < held_reg) && (bd_reg[j] > sum_reg);
    end

    assign gt_prev = {gt[MK-2:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd.start_scan) begin
            held_reg <= '0;
        end else if (v3_reg) begin
            // pos = number of slots not greater (list is sorted)
            if (held_reg < k_reg) held_reg <= held_reg + 1'b1;
            for (int j = 0; j < MK; j++) begin
                if ((KW'(j) < k_reg) && (gt[j] || KW'(j) == held_reg)) begin
                    if (!gt_prev[j]) begin
                        bd_reg[j] <= sum_reg;
                        bi_reg[j] <= i3_reg;
                    end else begin
                        bd_reg[j] <= bd_reg[(j > 0) ? j - 1 : 0];
                        bi_reg[j] <= bi_reg[(j > 0) ? j - 1 : 0];
                    end
                end
            end
        end
    end

    // emit pointer and output register
    logic [KW-1:0] ep_reg;
    logic          ov_reg;
    logic          take;
    assign take = ov_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.emit_start || cmd.load_vec) ep_reg <= '0;
        else if (cmd.emit_next)             ep_reg <= ep_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.emit_next || cmd.empty_out) begin
            ov_reg <= 1'b1;
        end else if (take) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.empty_out) begin
            out_index <= '0;
            out_dist  <= '0;
            out_found <= 1'b0;
            out_last  <= 1'b1;
        end else if (cmd.emit_next) begin
            out_index <= bi_reg[ep_reg[knn_pkg::SlotW-1:0]];
            out_dist  <= bd_reg[ep_reg[knn_pkg::SlotW-1:0]];
            out_found <= 1'b1;
            out_last  <= (ep_reg + 1'b1) == held_reg;
        end
    end

    assign out_valid = ov_reg;

    // status
    assign sts.scan_done  = scan_reg >= count_reg;
    assign sts.pipe_empty = !v1_reg && !v2_reg && !v3_reg;
    assign sts.held_zero  = held_reg == '0;
    assign sts.emit_last  = (ep_reg + 1'b1) == held_reg;
    assign sts.idx_bad    = bad_reg;

endmodule

// ===== src/knn_checker.sv =====
// Port-level checker for the k-nearest-neighbor search block.
module knn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic [95:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    // a not-found word always closes the query
    a_nf_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast) else $error("not-found without last");
    // not-found word carries zero payload
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0) else $error("not-found payload");
    // accepted input word is fully known
    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !$isunknown({s_tuser, s_tdata}))
        else $error("unknown input word");
    // offered output word is fully known
    a_out_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tuser, m_tlast}))
        else $error("unknown output word");
    // stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
        else $error("output dropped");
endmodule

bind k_nearest_neighbor_search knn_checker u_knn_checker (.*);
